/* sv/websocket_frame_builder_defines.svh */
// assertion macros shared by the frame builder modules
`ifndef WEBSOCKET_FRAME_BUILDER_DEFINES_SVH
`define WEBSOCKET_FRAME_BUILDER_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define WFB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked while out of reset
`define WFB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/wfb_pkg.sv */
// types and constants of the websocket frame builder
`default_nettype none

package wfb_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam logic       MODE_START = 1'b0;
    localparam logic       MODE_DATA  = 1'b1;

    localparam logic [1:0] CFG_OPCODE   = 2'd0;
    localparam logic [1:0] CFG_MASK_EN  = 2'd1;
    localparam logic [1:0] CFG_MASK_KEY = 2'd2;

    localparam logic [3:0]  OPCODE_RESET  = 4'h1;
    localparam logic        MASK_EN_RESET = 1'b1;
    localparam logic [31:0] MASK_KEY_RESET = 32'h0;

    localparam logic [7:0]  FIN_BIT    = 8'h80;
    localparam logic [31:0] SHORT_MAX  = 32'd125;
    localparam logic [31:0] MEDIUM_MAX = 32'd65535;
    localparam logic [6:0]  LEN16_CODE = 7'd126;
    localparam logic [6:0]  LEN64_CODE = 7'd127;

    localparam logic [3:0] HDR_SHORT_BYTES  = 4'd2;
    localparam logic [3:0] HDR_LEN16_BYTES  = 4'd4;
    localparam logic [3:0] HDR_LEN64_BYTES  = 4'd10;
    localparam logic [3:0] KEY_BYTES        = 4'd4;

    typedef enum logic [1:0] {
        LEN_SHORT,
        LEN_16,
        LEN_64
    } len_class_t;

    typedef struct packed {
        logic        mode;
        logic [31:0] payload_length;
        logic [7:0]  data_byte;
    } req_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        last;
        logic        end_of_frame;
        logic [32:0] frame_length;
    } rsp_t;

    // one queued job: a whole header burst or one payload byte
    typedef struct packed {
        logic        is_hdr;
        logic        eof;
        logic [7:0]  data;
        logic [3:0]  opcode;
        logic        mask_en;
        logic [31:0] key;
        logic [31:0] plen;
        len_class_t  lclass;
        logic [3:0]  nlen;
        logic [3:0]  nbytes;
        logic [32:0] flen;
    } cmd_t;

    typedef struct packed {
        logic valid;
        logic full;
    } queue_status_t;

endpackage

`default_nettype wire

/* sv/wfb_front.sv */
// front end: configuration registers, frame state and request classification
`default_nettype none
`include "websocket_frame_builder_defines.svh"

module wfb_front
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  req_valid,
    output logic                       req_ready,
    input  wire wfb_pkg::req_t         req_data,
    input  wire logic                  cfg_write,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [31:0]           cfg_data,
    input  wire wfb_pkg::queue_status_t qstat,
    output logic                       push,
    output wfb_pkg::cmd_t              cmd
);

    logic [3:0]  opcode_reg;
    logic        mask_en_reg;
    logic [31:0] key_reg;
    logic [31:0] rem_reg, rem_next;
    logic [1:0]  phase_reg, phase_next;
    logic        in_frame_reg, in_frame_next;

    logic        accept;
    logic        is_start;
    logic [31:0] plen;
    wfb_pkg::len_class_t lclass;
    logic [3:0]  nlen;
    logic [3:0]  nbytes;
    logic [7:0]  key_byte;
    logic        data_ok;

    assign req_ready = !qstat.full;
    assign accept    = req_valid && req_ready;
    assign is_start  = (req_data.mode == wfb_pkg::MODE_START);
    assign plen      = req_data.payload_length;
    assign data_ok   = in_frame_reg && (rem_reg != 32'd0);

    always_comb
    begin
        case (phase_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb
    begin
        if (plen <= wfb_pkg::SHORT_MAX)
        begin
            lclass = wfb_pkg::LEN_SHORT;
            nlen   = wfb_pkg::HDR_SHORT_BYTES;
        end
        else if (plen <= wfb_pkg::MEDIUM_MAX)
        begin
            lclass = wfb_pkg::LEN_16;
            nlen   = wfb_pkg::HDR_LEN16_BYTES;
        end
        else
        begin
            lclass = wfb_pkg::LEN_64;
            nlen   = wfb_pkg::HDR_LEN64_BYTES;
        end
        nbytes = mask_en_reg ? (nlen + wfb_pkg::KEY_BYTES) : nlen;
    end

    always_comb
    begin
        rem_next      = rem_reg;
        phase_next    = phase_reg;
        in_frame_next = in_frame_reg;
        push          = 1'b0;

        cmd.is_hdr  = is_start;
        cmd.eof     = 1'b0;
        cmd.data    = req_data.data_byte ^ (mask_en_reg ? key_byte : 8'h00);
        cmd.opcode  = opcode_reg;
        cmd.mask_en = mask_en_reg;
        cmd.key     = key_reg;
        cmd.plen    = plen;
        cmd.lclass  = lclass;
        cmd.nlen    = nlen;
        cmd.nbytes  = nbytes;
        cmd.flen    = {29'd0, nbytes} + {1'b0, plen};

        if (accept)
        begin
            if (is_start)
            begin
                push          = 1'b1;
                cmd.eof       = (plen == 32'd0);
                rem_next      = plen;
                phase_next    = 2'd0;
                in_frame_next = (plen != 32'd0);
            end
            else if (!data_ok)
            begin
                in_frame_next = 1'b0;
            end
            else
            begin
                push       = 1'b1;
                cmd.eof    = (rem_reg == 32'd1);
                rem_next   = rem_reg - 32'd1;
                phase_next = phase_reg + 2'd1;
                if (rem_reg == 32'd1)
                begin
                    in_frame_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opcode_reg   <= wfb_pkg::OPCODE_RESET;
            mask_en_reg  <= wfb_pkg::MASK_EN_RESET;
            key_reg      <= wfb_pkg::MASK_KEY_RESET;
            rem_reg      <= 32'd0;
            phase_reg    <= 2'd0;
            in_frame_reg <= 1'b0;
        end
        else
        begin
            rem_reg      <= rem_next;
            phase_reg    <= phase_next;
            in_frame_reg <= in_frame_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    wfb_pkg::CFG_OPCODE:   opcode_reg  <= cfg_data[3:0];
                    wfb_pkg::CFG_MASK_EN:  mask_en_reg <= cfg_data[0];
                    wfb_pkg::CFG_MASK_KEY: key_reg     <= cfg_data;
                    default:               ;
                endcase
            end
        end
    end

    `WFB_ASSERT_NOW(a_open_frame_has_bytes, in_frame_reg, rem_reg != 32'd0, "open frame with no bytes left")

endmodule

`default_nettype wire

/* sv/wfb_queue.sv */
// short job queue between front and back
`default_nettype none
`include "websocket_frame_builder_defines.svh"

module wfb_queue
#(
    parameter int DEPTH = wfb_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire wfb_pkg::cmd_t          push_data,
    input  wire logic                   pop,
    output wfb_pkg::cmd_t               head,
    output wfb_pkg::queue_status_t      qstat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    wfb_pkg::cmd_t     slots [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              do_push;
    logic              do_pop;

    assign qstat.valid = (cnt_reg != '0);
    assign qstat.full  = (cnt_reg == FULL_CNT);
    assign head        = slots[rd_ptr_reg];
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && qstat.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

    `WFB_ASSERT_NOW(a_no_push_when_full, qstat.full, !push, "push into full queue")
    `WFB_ASSERT_NEXT(a_push_leaves_entry, do_push && !do_pop, cnt_reg != '0, "pushed entry lost")

endmodule

`default_nettype wire

/* sv/wfb_back.sv */
// back end: expands queued jobs into frame bytes behind an output register
`default_nettype none
`include "websocket_frame_builder_defines.svh"

module wfb_back
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire wfb_pkg::cmd_t          head,
    input  wire wfb_pkg::queue_status_t qstat,
    output logic                        pop,
    output logic                        rsp_valid,
    input  wire logic                   rsp_ready,
    output wfb_pkg::rsp_t               rsp_data
);

    logic          rsp_valid_reg;
    wfb_pkg::rsp_t rsp_reg;
    logic [3:0]    idx_reg, idx_next;
    logic          load;
    logic          is_last;
    logic [7:0]    hdr_byte;
    logic [3:0]    key_idx;
    logic [7:0]    len_byte;
    wfb_pkg::rsp_t rsp_next;

    assign load    = qstat.valid && (!rsp_valid_reg || rsp_ready);
    assign is_last = !head.is_hdr || (idx_reg == head.nbytes - 4'd1);
    assign pop     = load && is_last;
    assign key_idx = idx_reg - head.nlen;

    always_comb
    begin
        case (head.lclass)
            wfb_pkg::LEN_SHORT: len_byte = {head.mask_en, head.plen[6:0]};
            wfb_pkg::LEN_16:    len_byte = {head.mask_en, wfb_pkg::LEN16_CODE};
            default:            len_byte = {head.mask_en, wfb_pkg::LEN64_CODE};
        endcase
    end

    always_comb
    begin
        hdr_byte = 8'h00;
        if (idx_reg >= head.nlen)
        begin
            case (key_idx[1:0])
                2'd0:    hdr_byte = head.key[31:24];
                2'd1:    hdr_byte = head.key[23:16];
                2'd2:    hdr_byte = head.key[15:8];
                default: hdr_byte = head.key[7:0];
            endcase
        end
        else
        begin
            case (idx_reg)
                4'd0: hdr_byte = wfb_pkg::FIN_BIT | {4'h0, head.opcode};
                4'd1: hdr_byte = len_byte;
                4'd2: hdr_byte = (head.lclass == wfb_pkg::LEN_16) ? head.plen[15:8] : 8'h00;
                4'd3: hdr_byte = (head.lclass == wfb_pkg::LEN_16) ? head.plen[7:0] : 8'h00;
                4'd6: hdr_byte = head.plen[31:24];
                4'd7: hdr_byte = head.plen[23:16];
                4'd8: hdr_byte = head.plen[15:8];
                4'd9: hdr_byte = head.plen[7:0];
                default: hdr_byte = 8'h00;
            endcase
        end
    end

    always_comb
    begin
        rsp_next.out_byte     = head.is_hdr ? hdr_byte : head.data;
        rsp_next.last         = is_last;
        rsp_next.end_of_frame = is_last && head.eof;
        rsp_next.frame_length = head.is_hdr ? head.flen : 33'd0;
        idx_next              = idx_reg;
        if (load)
        begin
            idx_next = is_last ? 4'd0 : idx_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            idx_reg       <= 4'd0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    `WFB_ASSERT_NOW(a_eof_is_last, rsp_valid_reg && rsp_reg.end_of_frame, rsp_reg.last, "frame end not last byte")
    `WFB_ASSERT_NOW(a_burst_on_header, idx_reg != 4'd0, qstat.valid && head.is_hdr, "byte index outside header burst")

endmodule

`default_nettype wire

/* sv/websocket_frame_builder.sv */
// top level of the websocket frame builder
//
//  channel  direction  handshake                      payload
//  req      in         req_valid / req_ready          req_data (mode, length, byte)
//  rsp      out        rsp_valid / rsp_ready          rsp_data (byte, last, eof, length)
//  cfg      in         cfg_write                      cfg_index, cfg_data
//
// an in-frame payload request yields one byte; one per cycle unless req_ready drops
// a start request yields a header burst of 2 to 14 bytes, one per cycle while rsp_ready
// the queue between front and back holds QUEUE_DEPTH jobs; req_ready drops when it is full
// the output register is reloaded in the same cycle its byte is taken, if a job is queued
// rst_n clears frame state, queue and output valid and loads register defaults
`default_nettype none

module websocket_frame_builder
#(
    parameter int QUEUE_DEPTH = wfb_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire wfb_pkg::req_t req_data,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output wfb_pkg::rsp_t      rsp_data,
    input  wire logic          cfg_write,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [31:0]   cfg_data
);

    wfb_pkg::cmd_t          cmd;
    wfb_pkg::cmd_t          head;
    wfb_pkg::queue_status_t qstat;
    logic                   push;
    logic                   pop;

    wfb_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .qstat     (qstat),
        .push      (push),
        .cmd       (cmd)
    );

    wfb_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (cmd),
        .pop       (pop),
        .head      (head),
        .qstat     (qstat)
    );

    wfb_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .qstat     (qstat),
        .pop       (pop),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

endmodule

`default_nettype wire

/* tb/websocket_frame_builder_tb.sv */
// self-checking testbench of the websocket frame builder: directed table, then random frames
`timescale 1ns / 100ps

module websocket_frame_builder_tb;

    localparam logic [1:0] CFG_UNUSED    = 2'd3;
    localparam int         SETTLE_CYCLES = 64;
    localparam int         IDLE_LIMIT    = 2000;
    localparam int         RANDOM_ITEMS  = 350;
    localparam int         MAX_BURST     = 40;
    localparam int         SCRIPT_ROWS   = 34;

    typedef enum logic {
        ROW_REQ,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic        mode;
        logic [31:0] value;
        logic [7:0]  aux;
        logic        typed;
        logic [3:0]  n;
        logic [7:0]  b0;
        logic [32:0] flen;
    } row_t;

    logic          clk;
    logic          rst_n;
    logic          req_valid;
    logic          req_ready;
    wfb_pkg::req_t req_data;
    logic          rsp_valid;
    logic          rsp_ready;
    wfb_pkg::rsp_t rsp_data;
    logic          cfg_write;
    logic [1:0]    cfg_index;
    logic [31:0]   cfg_data;

    // mirror of the block
    logic [3:0]  opcode_r;
    logic        mask_on;
    logic [31:0] key_r;
    logic [31:0] left_bytes;
    logic [1:0]  key_phase;
    logic        frame_open;

    wfb_pkg::rsp_t wire_bytes_q [$];
    int            mismatches;
    int            quiet_cycles;
    bit            tx_eager;
    row_t          script [SCRIPT_ROWS];

    websocket_frame_builder dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    function automatic logic [7:0] key_lane(input int k);
        return key_r[8 * (3 - k) +: 8];
    endfunction

    // expected wire bytes for one request, state updated as the block does
    function automatic int encode_request(input wfb_pkg::req_t r);
        logic [7:0]    hdr [$];
        logic [7:0]    mbit;
        logic [7:0]    b;
        logic [32:0]   flen;
        wfb_pkg::rsp_t e;
        int            i;
        mbit = mask_on ? 8'h80 : 8'h00;
        if (r.mode == wfb_pkg::MODE_START)
        begin
            hdr.push_back(wfb_pkg::FIN_BIT | {4'h0, opcode_r});
            if (r.payload_length <= wfb_pkg::SHORT_MAX)
                hdr.push_back({1'b0, r.payload_length[6:0]} | mbit);
            else if (r.payload_length <= wfb_pkg::MEDIUM_MAX)
            begin
                hdr.push_back({1'b0, wfb_pkg::LEN16_CODE} | mbit);
                hdr.push_back(r.payload_length[15:8]);
                hdr.push_back(r.payload_length[7:0]);
            end
            else
            begin
                hdr.push_back({1'b0, wfb_pkg::LEN64_CODE} | mbit);
                for (i = 0; i < 4; i++)
                    hdr.push_back(8'h00);
                for (i = 3; i >= 0; i--)
                    hdr.push_back(r.payload_length[8 * i +: 8]);
            end
            if (mask_on)
                for (i = 0; i < 4; i++)
                    hdr.push_back(key_lane(i));
            flen = 33'(hdr.size()) + {1'b0, r.payload_length};
            for (i = 0; i < hdr.size(); i++)
            begin
                e.out_byte     = hdr[i];
                e.last         = (i == hdr.size() - 1);
                e.end_of_frame = e.last && (r.payload_length == 32'd0);
                e.frame_length = flen;
                wire_bytes_q.push_back(e);
            end
            left_bytes = r.payload_length;
            key_phase  = 2'd0;
            frame_open = (r.payload_length != 32'd0);
            return hdr.size();
        end
        if (!frame_open || left_bytes == 32'd0)
        begin
            frame_open = 1'b0;
            return 0;
        end
        b = r.data_byte;
        if (mask_on)
            b = b ^ key_lane(int'(key_phase));
        key_phase  = key_phase + 2'd1;
        left_bytes = left_bytes - 32'd1;
        e.out_byte     = b;
        e.last         = 1'b1;
        e.end_of_frame = (left_bytes == 32'd0);
        e.frame_length = 33'd0;
        if (e.end_of_frame)
            frame_open = 1'b0;
        wire_bytes_q.push_back(e);
        return 1;
    endfunction

    function automatic row_t start_row(input logic [31:0] len, input logic typed, input int n,
                                       input logic [7:0] b0, input logic [32:0] flen);
        return '{ROW_REQ, wfb_pkg::MODE_START, len, 8'($urandom), typed, 4'(n), b0, flen};
    endfunction

    function automatic row_t data_row(input logic [7:0] b, input logic typed, input int n,
                                      input logic [7:0] b0);
        return '{ROW_REQ, wfb_pkg::MODE_DATA, $urandom, b, typed, 4'(n), b0, 33'd0};
    endfunction

    function automatic row_t cfg_row(input logic [1:0] idx, input logic [31:0] val);
        return '{ROW_CFG, wfb_pkg::MODE_START, val, {6'd0, idx}, 1'b0, 4'd0, 8'd0, 33'd0};
    endfunction

    task automatic send_request(input wfb_pkg::req_t r, output int n);
        int gap;
        gap = tx_eager ? 0 : $urandom_range(0, 8);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        n = encode_request(r);
    endtask

    task automatic drain_pipeline;
        req_valid <= 1'b0;
        while (wire_bytes_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            wfb_pkg::CFG_OPCODE:   opcode_r = val[3:0];
            wfb_pkg::CFG_MASK_EN:  mask_on  = val[0];
            wfb_pkg::CFG_MASK_KEY: key_r    = val;
            default:               ;
        endcase
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic shuffle_registers;
        logic [31:0] new_key;
        case ($urandom_range(0, 3))
            0:       new_key = 32'h0000_0000;
            1:       new_key = 32'hFFFF_FFFF;
            default: new_key = $urandom;
        endcase
        if ($urandom_range(0, 1) == 0)
            write_reg(wfb_pkg::CFG_OPCODE, $urandom);
        if ($urandom_range(0, 1) == 0)
            write_reg(wfb_pkg::CFG_MASK_EN, $urandom);
        if ($urandom_range(0, 1) == 0)
            write_reg(wfb_pkg::CFG_MASK_KEY, new_key);
        if ($urandom_range(0, 9) == 0)
            write_reg(CFG_UNUSED, $urandom);
    endtask

    task automatic check_wire_byte(input wfb_pkg::rsp_t got);
        wfb_pkg::rsp_t want;
        if (wire_bytes_q.size() == 0)
        begin
            report_mismatch($sformatf("unexpected byte %02h", got.out_byte));
            return;
        end
        want = wire_bytes_q.pop_front();
        if (got.out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte got %02h want %02h",
                                      got.out_byte, want.out_byte));
        if (got.last !== want.last)
            report_mismatch($sformatf("last got %b want %b", got.last, want.last));
        if (got.end_of_frame !== want.end_of_frame)
            report_mismatch($sformatf("end_of_frame got %b want %b",
                                      got.end_of_frame, want.end_of_frame));
        if (got.frame_length !== want.frame_length)
            report_mismatch($sformatf("frame_length got %0d want %0d",
                                      got.frame_length, want.frame_length));
    endtask

    initial
    begin : receiver
        int stall;
        bit rx_eager;
        rx_eager = 1'b0;
        rsp_ready <= 1'b0;
        forever
        begin
            if ($urandom_range(0, 49) == 0)
                rx_eager = !rx_eager;
            stall = rx_eager ? 0 : $urandom_range(0, 8);
            if (stall != 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            @(posedge clk);
            while (!rsp_valid) @(posedge clk);
            check_wire_byte(rsp_data);
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin : stimulus
        wfb_pkg::req_t r;
        int            n;
        int            idx;
        int            pick;
        int            body;
        int            nsend;
        int            produced_items;
        logic [31:0]   len;

        rst_n        <= 1'b0;
        req_valid    <= 1'b0;
        req_data     <= '0;
        cfg_write    <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        mismatches   = 0;
        quiet_cycles = 0;
        tx_eager     = 1'b0;
        opcode_r     = wfb_pkg::OPCODE_RESET;
        mask_on      = wfb_pkg::MASK_EN_RESET;
        key_r        = wfb_pkg::MASK_KEY_RESET;
        left_bytes   = 32'd0;
        key_phase    = 2'd0;
        frame_open   = 1'b0;

        script = '{
            start_row(32'd0, 1'b1, 6, 8'h81, 33'd6),
            data_row(8'hA5, 1'b1, 0, 8'h00),
            start_row(32'd3, 1'b1, 6, 8'h81, 33'd9),
            data_row(8'h00, 1'b1, 1, 8'h00),
            data_row(8'hFF, 1'b1, 1, 8'hFF),
            cfg_row(wfb_pkg::CFG_MASK_KEY, 32'hFFFF_FFFF),
            data_row(8'h3C, 1'b1, 1, 8'hC3),
            data_row(8'h11, 1'b1, 0, 8'h00),
            cfg_row(wfb_pkg::CFG_OPCODE, 32'd15),
            cfg_row(wfb_pkg::CFG_MASK_EN, 32'd0),
            start_row(32'd125, 1'b1, 2, 8'h8F, 33'd127),
            data_row(8'h5A, 1'b1, 1, 8'h5A),
            start_row(32'd126, 1'b1, 4, 8'h8F, 33'd130),
            data_row(8'h80, 1'b1, 1, 8'h80),
            cfg_row(wfb_pkg::CFG_OPCODE, 32'd0),
            cfg_row(wfb_pkg::CFG_MASK_EN, 32'd1),
            cfg_row(wfb_pkg::CFG_MASK_KEY, 32'hA5C3_0F96),
            start_row(32'd65535, 1'b1, 8, 8'h80, 33'd65543),
            data_row(8'h00, 1'b0, 1, 8'h00),
            data_row(8'hFF, 1'b0, 1, 8'h00),
            data_row(8'h12, 1'b0, 1, 8'h00),
            data_row(8'h34, 1'b0, 1, 8'h00),
            data_row(8'h56, 1'b0, 1, 8'h00),
            start_row(32'd65536, 1'b1, 14, 8'h80, 33'd65550),
            data_row(8'hEE, 1'b0, 1, 8'h00),
            start_row(32'hFFFF_FFFF, 1'b1, 14, 8'h80, 33'h1_0000_000D),
            cfg_row(CFG_UNUSED, 32'hFFFF_FFFF),
            start_row(32'd1, 1'b1, 6, 8'h80, 33'd7),
            data_row(8'h77, 1'b0, 1, 8'h00),
            cfg_row(wfb_pkg::CFG_OPCODE, 32'hFFFF_FFF8),
            cfg_row(wfb_pkg::CFG_MASK_EN, 32'hFFFF_FFFE),
            start_row(32'd0, 1'b1, 2, 8'h88, 33'd2),
            start_row(32'd2, 1'b1, 2, 8'h88, 33'd4),
            data_row(8'hC7, 1'b0, 1, 8'h00)
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            if (script[i].kind == ROW_CFG)
            begin
                drain_pipeline();
                write_reg(script[i].aux[1:0], script[i].value);
            end
            else
            begin
                r.mode           = script[i].mode;
                r.payload_length = script[i].value;
                r.data_byte      = script[i].aux;
                send_request(r, n);
                if (script[i].typed)
                begin
                    if (n != int'(script[i].n))
                        report_mismatch($sformatf("row %0d: %0d bytes predicted, table says %0d",
                                                  i, n, script[i].n));
                    else if (n != 0)
                    begin
                        idx = wire_bytes_q.size() - n;
                        wire_bytes_q[idx].out_byte     = script[i].b0;
                        wire_bytes_q[idx].frame_length = script[i].flen;
                    end
                end
            end
        end

        // random frames: some well formed, others cut short or overrun, some stray bytes
        produced_items = 0;
        while (produced_items < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                drain_pipeline();
                shuffle_registers();
            end
            tx_eager = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 19) == 0)
            begin
                r = '{wfb_pkg::MODE_DATA, $urandom, 8'($urandom)};
                send_request(r, n);
                if (n != 0)
                    produced_items++;
            end
            pick = $urandom_range(0, 99);
            if (pick < 45)
                len = $urandom_range(0, 10);
            else if (pick < 65)
                len = $urandom_range(11, 125);
            else if (pick < 80)
                len = $urandom_range(126, 65535);
            else if (pick < 90)
                len = $urandom_range(32'd65536, 32'hFFFF_FFFF);
            else
                len = $urandom;
            r = '{wfb_pkg::MODE_START, len, 8'($urandom)};
            send_request(r, n);
            produced_items++;
            body = (len > 32'(MAX_BURST)) ? MAX_BURST : int'(len);
            pick = $urandom_range(0, 99);
            if (pick < 65)
                nsend = body;
            else if (pick < 85)
                nsend = body + $urandom_range(1, 3);
            else
                nsend = $urandom_range(0, body);
            for (int k = 0; k < nsend; k++)
            begin
                if ($urandom_range(0, 39) == 0)
                begin
                    drain_pipeline();
                    shuffle_registers();
                end
                r = '{wfb_pkg::MODE_DATA, $urandom, 8'($urandom)};
                send_request(r, n);
                if (n != 0)
                    produced_items++;
            end
        end

        drain_pipeline();
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
